// ===== rtl/core/pca_pkg.sv =====
// shared types, constants and register codes of the pixel color adjust block
`timescale 1ns / 1ps
`default_nettype none

package pca_pkg;

    // default channel width, table depth follows as 2**CHANNEL_BITS
    localparam int unsigned CHANNEL_BITS_DEF = 8;

    // configuration register widths and indexes
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned GAIN_W      = 18;
    localparam int unsigned OFFSET_W    = 17;
    localparam int unsigned CFG_DATA_W  = 18;

    localparam logic [CFG_INDEX_W-1:0] CFG_MODE         = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAT_GAIN     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LIGHT_OFFSET = 2'd2;

    // saturation gain has 12 fraction bits, divisor is 3 * 4096
    localparam int unsigned SAT_FRAC = 12;
    localparam int unsigned SAT_DEN  = 3 << SAT_FRAC;
    localparam int unsigned SAT_HALF = SAT_DEN / 2;

    // lightness offset is in 1/256 code steps
    localparam int unsigned LIGHT_FRAC = 8;
    localparam int unsigned LIGHT_HALF = 1 << (LIGHT_FRAC - 1);

    // input word kinds carried on tuser
    localparam logic ACTION_PIXEL       = 1'b0;
    localparam logic ACTION_TABLE_WRITE = 1'b1;

    typedef enum logic [1:0] {
        MODE_PASS  = 2'd0,
        MODE_GAMMA = 2'd1,
        MODE_SAT   = 2'd2,
        MODE_LIGHT = 2'd3
    } mode_t;

    // per-stage load strobes of the channel pipeline
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } pipe_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/pca_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module pca_ram #(
    parameter  int unsigned DATA_W = 8,
    parameter  int unsigned DEPTH  = 256,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pca_chan.sv =====
// one color channel: gamma table copy and four-stage adjust datapath
`timescale 1ns / 1ps
`default_nettype none

module pca_chan #(
    parameter int unsigned CHANNEL_BITS = pca_pkg::CHANNEL_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire pca_pkg::pipe_ctrl_t                 ctrl,
    input  wire pca_pkg::mode_t                      mode,
    input  wire logic signed [pca_pkg::GAIN_W-1:0]   gain,
    input  wire logic signed [pca_pkg::OFFSET_W-1:0] offset,
    input  wire logic                                tbl_we,
    input  wire logic        [CHANNEL_BITS-1:0]      tbl_addr,
    input  wire logic        [CHANNEL_BITS-1:0]      tbl_data,
    input  wire logic        [CHANNEL_BITS-1:0]      c_in,
    input  wire logic        [CHANNEL_BITS+1:0]      sum1,
    output logic             [CHANNEL_BITS-1:0]      c_out
);

    localparam int unsigned W     = CHANNEL_BITS;
    localparam int unsigned DEPTH = 1 << W;
    localparam int unsigned DW    = W + 3;
    localparam int unsigned PW    = DW + pca_pkg::GAIN_W;
    localparam int unsigned TW    = PW + 1;
    localparam int unsigned LW    = W + 10;
    localparam int unsigned QW    = W + 2;
    localparam int unsigned RS    = W + 4;
    localparam int unsigned RK    = (1 << RS) / 3 + 1;
    localparam int unsigned QKW   = 2 * W + 6;
    localparam logic signed [TW-1:0] SAT_LIM =
        TW'((64'd1 << W) * pca_pkg::SAT_DEN);
    localparam logic [W-1:0] CODE_MAX = '1;

    // stage 1
    logic        [W-1:0]  c1_reg;
    logic        [W-1:0]  gam1;
    logic        [W+1:0]  c3;
    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] prod;

    // stage 2
    logic signed [PW-1:0] prod2_reg;
    logic        [W-1:0]  c2_reg;
    logic        [W-1:0]  gam2_reg;
    logic signed [TW-1:0] c_ext;
    logic signed [TW-1:0] sat_t;
    logic signed [LW-1:0] light_t;
    logic        [W-1:0]  light_res;
    logic        [W-1:0]  other;

    // stage 3
    logic [QW-1:0]  q3_reg;
    logic           sat_neg3_reg;
    logic           sat_hi3_reg;
    logic [W-1:0]   other3_reg;
    logic [QKW-1:0] qk;
    logic [W-1:0]   result;

    // stage 4
    logic [W-1:0] out4_reg;

    pca_ram #(
        .DATA_W (W),
        .DEPTH  (DEPTH)
    ) u_gamma (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_addr),
        .wdata (tbl_data),
        .re    (ctrl.ld1),
        .raddr (c_in),
        .rdata (gam1)
    );

    always_comb begin
        c3   = {2'b00, c1_reg} + {1'b0, c1_reg, 1'b0};
        diff = $signed({1'b0, c3}) - $signed({1'b0, sum1});
        prod = PW'(diff) * PW'(gain);
    end

    always_comb begin
        c_ext   = $signed(TW'(c2_reg));
        sat_t   = TW'(prod2_reg) + (c_ext <<< (pca_pkg::SAT_FRAC + 1))
                + (c_ext <<< pca_pkg::SAT_FRAC) + TW'(pca_pkg::SAT_HALF);
        light_t = ($signed(LW'(c2_reg)) <<< pca_pkg::LIGHT_FRAC) + LW'(offset)
                + LW'(pca_pkg::LIGHT_HALF);
        if (light_t[LW-1]) begin
            light_res = '0;
        end else if (light_t[W+pca_pkg::LIGHT_FRAC]) begin
            light_res = CODE_MAX;
        end else begin
            light_res = light_t[pca_pkg::LIGHT_FRAC +: W];
        end
        case (mode)
            pca_pkg::MODE_PASS:  other = c2_reg;
            pca_pkg::MODE_GAMMA: other = gam2_reg;
            pca_pkg::MODE_LIGHT: other = light_res;
            default:             other = c2_reg;
        endcase
    end

    // divide by three through a reciprocal, exact for q below 3 * 2**W
    always_comb begin
        qk = QKW'(q3_reg) * QKW'(RK);
        if (mode == pca_pkg::MODE_SAT) begin
            if (sat_neg3_reg) begin
                result = '0;
            end else if (sat_hi3_reg) begin
                result = CODE_MAX;
            end else begin
                result = qk[RS +: W];
            end
        end else begin
            result = other3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld1) begin
            c1_reg <= c_in;
        end
        if (ctrl.ld2) begin
            prod2_reg <= prod;
            c2_reg    <= c1_reg;
            gam2_reg  <= gam1;
        end
        if (ctrl.ld3) begin
            q3_reg       <= sat_t[pca_pkg::SAT_FRAC +: QW];
            sat_neg3_reg <= sat_t[TW-1];
            sat_hi3_reg  <= (sat_t >= SAT_LIM);
            other3_reg   <= other;
        end
        if (ctrl.ld4) begin
            out4_reg <= result;
        end
    end

    assign c_out = out4_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pixel_color_adjust.sv =====
// pixel color adjust top level: config registers, table init, pipeline control
//
//  channel | direction | tdata (low bit up)                       | tuser  | tlast
//  s_      | in        | blue, green, red, table_index, table_value | action | last_pixel
//  m_      | out       | blue_out, green_out, red_out              | -      | last_pixel_out
//  cfg_    | in        | write enable, index, data (no read-back)  | -      | -
//
// one word per clock while m_ takes its words and no table init runs; a pixel accepted
// on s_ passes the four-stage datapath (table read, gain multiply, round/clamp, divide by three)
// to m_; table writes finish at acceptance and give no output
// after reset the gamma tables are loaded with identity over every entry,
// with s_tready low meanwhile; config writes are taken at any time
// each stage holds its word only while the next one is full, so a waiting
// output does not stop acceptance until the pipeline is full
`timescale 1ns / 1ps
`default_nettype none

module pixel_color_adjust #(
    parameter  int unsigned CHANNEL_BITS = pca_pkg::CHANNEL_BITS_DEF,
    localparam int unsigned S_DATA_W = ((5 * CHANNEL_BITS + 7) / 8) * 8,
    localparam int unsigned M_DATA_W = ((3 * CHANNEL_BITS + 7) / 8) * 8
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [pca_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [pca_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // blue, green, red, table_index, table_value, zero pad
    input  wire logic [S_DATA_W-1:0]                s_tdata,
    // action
    input  wire logic                               s_tuser,
    input  wire logic                               s_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // blue_out, green_out, red_out, zero pad
    output logic [M_DATA_W-1:0]                     m_tdata,
    output logic                                    m_tlast
);

    localparam int unsigned W = CHANNEL_BITS;

    pca_pkg::mode_t                      mode_reg;
    logic signed [pca_pkg::GAIN_W-1:0]   gain_reg;
    logic signed [pca_pkg::OFFSET_W-1:0] offset_reg;

    logic         clearing_reg;
    logic [W-1:0] clr_idx_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic free1, free2, free3, free4;
    logic mv1, mv2, mv3;
    logic s_acc, pix_acc, tbl_acc;

    logic         last1_reg, last2_reg, last3_reg, last4_reg;
    logic [W+1:0] sum1_reg;
    logic [W+1:0] sum_in;

    logic [W-1:0] in_blue, in_green, in_red, in_index, in_value;
    logic         tbl_we;
    logic [W-1:0] tbl_addr, tbl_data;
    logic [W-1:0] out_blue, out_green, out_red;

    pca_pkg::pipe_ctrl_t ctrl;

    assign in_blue  = s_tdata[0*W +: W];
    assign in_green = s_tdata[1*W +: W];
    assign in_red   = s_tdata[2*W +: W];
    assign in_index = s_tdata[3*W +: W];
    assign in_value = s_tdata[4*W +: W];

    assign sum_in = {2'b00, in_blue} + {2'b00, in_green} + {2'b00, in_red};

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= pca_pkg::MODE_PASS;
            gain_reg   <= '0;
            offset_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                pca_pkg::CFG_MODE:
                    mode_reg <= pca_pkg::mode_t'(cfg_wdata[1:0]);
                pca_pkg::CFG_SAT_GAIN:
                    gain_reg <= $signed(cfg_wdata[pca_pkg::GAIN_W-1:0]);
                pca_pkg::CFG_LIGHT_OFFSET:
                    offset_reg <= $signed(cfg_wdata[pca_pkg::OFFSET_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    // identity load sweep of the gamma tables
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else if (clearing_reg) begin
            clr_idx_reg <= clr_idx_reg + W'(1);
            if (clr_idx_reg == '1) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // pipeline occupancy, computed from the output back
    always_comb begin
        free4    = !v4_reg || m_tready;
        mv3      = v3_reg && free4;
        free3    = !v3_reg || free4;
        mv2      = v2_reg && free3;
        free2    = !v2_reg || free3;
        mv1      = v1_reg && free2;
        free1    = !v1_reg || free2;
        s_tready = free1 && !clearing_reg;
        s_acc    = s_tvalid && s_tready;
        pix_acc  = s_acc && (s_tuser == pca_pkg::ACTION_PIXEL);
        tbl_acc  = s_acc && (s_tuser == pca_pkg::ACTION_TABLE_WRITE);
        ctrl.ld1 = pix_acc;
        ctrl.ld2 = mv1;
        ctrl.ld3 = mv2;
        ctrl.ld4 = mv3;
    end

    always_comb begin
        v1_next = pix_acc ? 1'b1 : (mv1 ? 1'b0 : v1_reg);
        v2_next = mv1 ? 1'b1 : (mv2 ? 1'b0 : v2_reg);
        v3_next = mv2 ? 1'b1 : (mv3 ? 1'b0 : v3_reg);
        v4_next = mv3 ? 1'b1 : (m_tready ? 1'b0 : v4_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.ld1) begin
            last1_reg <= s_tlast;
            sum1_reg  <= sum_in;
        end
        if (ctrl.ld2) begin
            last2_reg <= last1_reg;
        end
        if (ctrl.ld3) begin
            last3_reg <= last2_reg;
        end
        if (ctrl.ld4) begin
            last4_reg <= last3_reg;
        end
    end

    // table write port: identity sweep first, then table-write words
    always_comb begin
        if (clearing_reg) begin
            tbl_we   = 1'b1;
            tbl_addr = clr_idx_reg;
            tbl_data = clr_idx_reg;
        end else begin
            tbl_we   = tbl_acc;
            tbl_addr = in_index;
            tbl_data = in_value;
        end
    end

    pca_chan #(.CHANNEL_BITS(W)) u_chan_blue (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .mode     (mode_reg),
        .gain     (gain_reg),
        .offset   (offset_reg),
        .tbl_we   (tbl_we),
        .tbl_addr (tbl_addr),
        .tbl_data (tbl_data),
        .c_in     (in_blue),
        .sum1     (sum1_reg),
        .c_out    (out_blue)
    );

    pca_chan #(.CHANNEL_BITS(W)) u_chan_green (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .mode     (mode_reg),
        .gain     (gain_reg),
        .offset   (offset_reg),
        .tbl_we   (tbl_we),
        .tbl_addr (tbl_addr),
        .tbl_data (tbl_data),
        .c_in     (in_green),
        .sum1     (sum1_reg),
        .c_out    (out_green)
    );

    pca_chan #(.CHANNEL_BITS(W)) u_chan_red (
        .aclk     (aclk),
        .ctrl     (ctrl),
        .mode     (mode_reg),
        .gain     (gain_reg),
        .offset   (offset_reg),
        .tbl_we   (tbl_we),
        .tbl_addr (tbl_addr),
        .tbl_data (tbl_data),
        .c_in     (in_red),
        .sum1     (sum1_reg),
        .c_out    (out_red)
    );

    assign m_tvalid = v4_reg;
    assign m_tdata  = M_DATA_W'({out_red, out_green, out_blue});
    assign m_tlast  = last4_reg;

    // no word is taken while the tables are being initialized
    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s_tready)
        else $error("input accepted during table init");

    // a table write never starts a result
    a_tbl_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (tbl_acc && !v1_reg) |=> !v1_reg)
        else $error("table write entered the pipeline");

    // a stalled first stage keeps its word
    a_stage1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !mv1) |=> v1_reg)
        else $error("stage one word lost");

    // the init sweep ends after covering every entry
    a_sweep_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(clearing_reg) |-> (clr_idx_reg == '0))
        else $error("table init ended early");

endmodule

`default_nettype wire
